// File: sv/htfe_pkg.sv
// shared constants for the head/tail frame extractor
// register indexes, reset values and sizing defaults; no dependencies
`default_nettype none
package htfe_pkg;

    localparam int FRAME_BYTES_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int LEN_W      = 7;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEN_TAIL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_LEN   = 3'd4;

    localparam logic [LEN_W-1:0] BUF_LEN_RST = 7'd64;

    // earliest store position at which a frame may close
    localparam int TAIL_MIN_INDEX = 4;
    // positions kept back from the end of the buffer
    localparam int LEN_MARGIN = 2;

endpackage
`default_nettype wire

// File: sv/head_tail_frame_extractor_core.sv
// output: the first byte of a frame is shown in the cycle after its closing byte is taken
// throughput: one byte per cycle in while no frame is read out; a closed frame is read
// out of the store one byte per cycle while i_out_stall is low, input stalled meanwhile
// reset: synchronous active low, clears frame state and registers (buffer length 64);
// the frame store is not cleared
// uses htfe_pkg and htfe_store
`default_nettype none
module head_tail_frame_extractor_core #(
    parameter int FRAME_BYTES = htfe_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [htfe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [htfe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [7:0]                       i_data_byte,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [7:0]                            o_frame_byte,
    output logic                                  o_end_of_frame
);

    localparam int IW = $clog2(FRAME_BYTES);
    localparam int LW = (IW + 1 > htfe_pkg::LEN_W) ? IW + 1 : htfe_pkg::LEN_W;

    logic [7:0]                  r_head, r_second, r_pen_tail, r_tail;
    logic [htfe_pkg::LEN_W-1:0]  r_buf_len;

    logic          r_in_frame, n_in_frame;
    logic [IW-1:0] r_wi, n_wi;
    logic [7:0]    r_prev, n_prev;
    logic          r_emit, n_emit;
    logic [IW-1:0] r_last, n_last;
    logic [IW-1:0] r_rd_addr, n_rd_addr;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [7:0]    w_rdata;
    logic [LW-1:0] w_len, w_limit;
    logic          w_in_acc, w_out_acc, w_second_bad, w_close;

    assign w_in_acc  = i_in_valid && !r_emit;
    assign w_out_acc = r_emit && !i_out_stall;

    always_comb begin
        w_len = LW'(r_buf_len);
        if (w_len > LW'(FRAME_BYTES)) begin
            w_len = LW'(FRAME_BYTES);
        end
        if (w_len < LW'(htfe_pkg::LEN_MARGIN)) begin
            w_len = LW'(htfe_pkg::LEN_MARGIN);
        end
        w_limit = w_len - LW'(htfe_pkg::LEN_MARGIN);
    end

    assign w_second_bad = (r_second != 8'd0) && r_in_frame && (r_wi == IW'(1))
                          && (i_data_byte != r_second);

    // closes on tail with the previous stored byte equal to the penultimate
    assign w_close = (r_wi >= IW'(htfe_pkg::TAIL_MIN_INDEX)) && (i_data_byte == r_tail)
                     && (r_pen_tail != 8'd0) && (r_prev == r_pen_tail);

    always_comb begin
        n_in_frame = r_in_frame;
        n_wi       = r_wi;
        n_prev     = r_prev;
        n_emit     = r_emit;
        n_last     = r_last;
        n_rd_addr  = r_rd_addr;
        w_we       = 1'b0;
        w_waddr    = r_wi;
        if (w_in_acc) begin
            priority if (!r_in_frame || w_second_bad) begin
                if (i_data_byte == r_head) begin
                    w_we       = 1'b1;
                    w_waddr    = '0;
                    n_wi       = IW'(1);
                    n_in_frame = 1'b1;
                    n_prev     = i_data_byte;
                end else begin
                    n_wi       = '0;
                    n_in_frame = 1'b0;
                end
            end else if (LW'(r_wi) >= w_limit) begin
                n_wi       = '0;
                n_in_frame = 1'b0;
            end else begin
                w_we = 1'b1;
                if (w_close) begin
                    n_emit     = 1'b1;
                    n_last     = r_wi;
                    n_rd_addr  = '0;
                    n_wi       = '0;
                    n_in_frame = 1'b0;
                end else begin
                    n_wi   = r_wi + IW'(1);
                    n_prev = i_data_byte;
                end
            end
        end
        if (w_out_acc) begin
            if (r_rd_addr == r_last) begin
                n_emit = 1'b0;
            end else begin
                n_rd_addr = r_rd_addr + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_second   <= '0;
            r_pen_tail <= '0;
            r_tail     <= '0;
            r_buf_len  <= htfe_pkg::BUF_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                htfe_pkg::REG_HEAD:     r_head     <= i_cfg_data;
                htfe_pkg::REG_SECOND:   r_second   <= i_cfg_data;
                htfe_pkg::REG_PEN_TAIL: r_pen_tail <= i_cfg_data;
                htfe_pkg::REG_TAIL:     r_tail     <= i_cfg_data;
                htfe_pkg::REG_BUF_LEN:  r_buf_len  <= i_cfg_data[htfe_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_wi       <= '0;
            r_emit     <= 1'b0;
            r_rd_addr  <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_wi       <= n_wi;
            r_emit     <= n_emit;
            r_rd_addr  <= n_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_last <= n_last;
    end

    // read address follows the next pointer so read data lines up with r_rd_addr
    htfe_store #(
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_data_byte),
        .i_raddr (n_rd_addr),
        .o_rdata (w_rdata)
    );

    assign o_in_stall     = r_emit;
    assign o_out_valid    = r_emit;
    assign o_frame_byte   = w_rdata;
    assign o_end_of_frame = (r_rd_addr == r_last);

endmodule
`default_nettype wire

// File: sv/htfe_store.sv
// frame byte store: one write port, one read port, registered read data
// sized by DEPTH from the top level; no package use
`default_nettype none
module htfe_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]                    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sv/htfe_checker.sv
// port-level checks for head_tail_frame_extractor_core, bound to the top level
// depends only on the top level's ports
`default_nettype none
module htfe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_frame_byte,
    input wire logic       o_end_of_frame
);

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_byte)
            && $stable(o_end_of_frame))
        else $error("stalled output word changed");

    // no input taken while a frame is read out
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during frame readout");

    // output stops right after the last word of a frame
    a_eof_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_end_of_frame |=> !o_out_valid)
        else $error("output continued past end of frame");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

endmodule

bind head_tail_frame_extractor_core htfe_checker u_htfe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_frame_byte   (o_frame_byte),
    .o_end_of_frame (o_end_of_frame)
);
`default_nettype wire
